@@ design/rkc_pkg.sv @@
// Package: shared constants, types and saturating helpers for the RK4 stage combiner.
`default_nettype none
package rkc_pkg;

    // Vector storage depth and derived index widths
    localparam int MAX_ELEMENTS = 64;
    localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W        = 7;
    localparam int NUM_W        = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

    // Data path widths
    localparam int DATA_W = 32;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int CFG_W  = 1;

    // floor(a / 3) == (a * RECIP3) >> RECIP_SH for any 32-bit unsigned a
    localparam logic [MUL_W-1:0] RECIP3   = 33'h0AAAAAAAB;
    localparam int               RECIP_SH = 33;

    // Reset values of the configuration registers
    localparam logic signed [DATA_W-1:0] TIME_STEP_RST     = 32'sh0001_0000;
    localparam logic        [CNT_W-1:0]  ELEMENT_COUNT_RST = 7'd6;

    typedef enum logic [CFG_W-1:0] {
        CFG_TIME_STEP     = 1'b0,
        CFG_ELEMENT_COUNT = 1'b1
    } t_cfg_index;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_DERIV = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MULK,
        S_ROUND,
        S_DIV,
        S_ACC,
        S_OUT
    } t_state;

    // Control strobes from the sequencer
    typedef struct packed {
        logic in_ready;
        logic mul_en;
        logic mul_div;
        logic ram_re;
        logic load_we;
        logic sum_we;
        logic out_load;
    } t_ctrl;

    // Add two Q16.16 values and clamp to the 32-bit signed range
    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            sat_add = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            sat_add = s[DATA_W-1:0];
        end
    endfunction

    // Halve with round to nearest, ties toward plus infinity
    function automatic logic signed [DATA_W-1:0] half_round(
        input logic signed [DATA_W-1:0] a
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {{DATA_W{1'b0}}, 1'b1};
        half_round = s[DATA_W:1];
    endfunction

endpackage
`default_nettype wire

@@ design/rkc_if.sv @@
// Interfaces: input item channel, result channel and configuration write channel.
`default_nettype none
interface rkc_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 opcode;
    logic signed [rkc_pkg::DATA_W-1:0]    value;
    logic signed [rkc_pkg::DATA_W-1:0]    step_time;

    modport source (output valid, output opcode, output value, output step_time, input ready);
    modport sink   (input valid, input opcode, input value, input step_time, output ready);
endinterface

interface rkc_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rkc_pkg::DATA_W-1:0]    element;
    logic                                 is_final;
    logic signed [rkc_pkg::DATA_W-1:0]    eval_time;
    logic                                 last;

    modport source (output valid, output element, output is_final, output eval_time,
                    output last, input ready);
    modport sink   (input valid, input element, input is_final, input eval_time,
                    input last, output ready);
endinterface

interface rkc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [rkc_pkg::CFG_W-1:0]            index;
    logic [rkc_pkg::DATA_W-1:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ design/rk4_stage_combiner.sv @@
// Top level: sequencer and data path of the RK4 stage combiner.
// A load item is accepted in S_IDLE and written to both vector RAMs in S_LOAD.
// A derivative item passes S_MULK, S_ROUND, S_DIV and S_ACC, has its result registered in
// S_OUT and only then lets the block take the next item in S_IDLE; the multiplier runs twice.
// Results sit in an output register, so a stalled sink holds the sequencer only in S_OUT.
// Synchronous active-low reset: dt = 1.0, element count 6, expecting a state load.
`default_nettype none
module rk4_stage_combiner (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rkc_in_if.sink     i_in,
    rkc_out_if.source  o_out,
    rkc_cfg_if.sink    i_cfg
);
    localparam int IDX_W  = rkc_pkg::IDX_W;
    localparam int NUM_W  = rkc_pkg::NUM_W;
    localparam int DW     = rkc_pkg::DATA_W;
    localparam int MW     = rkc_pkg::MUL_W;
    localparam int PW     = rkc_pkg::PROD_W;
    localparam int SHW    = PW - 16;

    rkc_pkg::t_state r_state, n_state;
    rkc_pkg::t_ctrl  ctrl;

    // Control state
    logic                        r_loading;
    logic [1:0]                  r_stage;
    logic [IDX_W-1:0]            r_idx;
    logic signed [DW-1:0]        r_start_time;
    logic signed [DW-1:0]        r_time_step;
    logic [rkc_pkg::CNT_W-1:0]   r_count;
    logic                        r_out_valid;

    // Payload registers
    logic                        r_op;
    logic signed [DW-1:0]        r_value;
    logic signed [DW-1:0]        r_step_time;
    logic signed [DW-1:0]        r_k;
    logic signed [DW-1:0]        r_ws_new;
    logic signed [DW-1:0]        r_out_element;
    logic                        r_out_final;
    logic signed [DW-1:0]        r_out_time;
    logic                        r_out_last;

    logic                        in_accept;
    logic                        cfg_accept;
    logic [NUM_W-1:0]            num_active;
    logic [IDX_W-1:0]            load_idx;
    logic                        load_last;
    logic                        deriv_last;
    logic                        div6;
    logic signed [MW-1:0]        mul_a, mul_b;
    logic signed [PW-1:0]        prod;
    logic signed [PW-1:0]        prod_rnd;
    logic signed [SHW-1:0]       prod_sh;
    logic signed [DW-1:0]        k_sat;
    logic [DW-1:0]               abs_k;
    logic [DW-1:0]               div_arg;
    logic [DW-1:0]               q3;
    logic [DW-1:0]               q;
    logic signed [DW-1:0]        q_signed;
    logic signed [DW-1:0]        ss_rd, ws_rd;
    logic signed [DW-1:0]        ws_sum;
    logic signed [DW-1:0]        sk, hdt;
    logic signed [DW-1:0]        elem_next;
    logic signed [DW-1:0]        time_next;
    logic [IDX_W-1:0]            ram_waddr;
    logic signed [DW-1:0]        ss_wdata, ws_wdata;

    assign in_accept  = i_in.valid && ctrl.in_ready;
    assign cfg_accept = i_cfg.valid;

    // Clamp the element count to 1..MAX_ELEMENTS
    always_comb begin
        if (r_count == '0) begin
            num_active = NUM_W'(1);
        end else if (NUM_W'(r_count) > NUM_W'(rkc_pkg::MAX_ELEMENTS)) begin
            num_active = NUM_W'(rkc_pkg::MAX_ELEMENTS);
        end else begin
            num_active = NUM_W'(r_count);
        end
    end

    // A load during the stages restarts at element 0
    assign load_idx   = r_loading ? r_idx : '0;
    assign load_last  = (NUM_W'(load_idx) + NUM_W'(1)) >= num_active;
    assign deriv_last = (NUM_W'(r_idx) + NUM_W'(1)) >= num_active;
    assign div6       = (r_stage == 2'd0) || (r_stage == 2'd3);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rkc_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (rkc_pkg::t_opcode'(i_in.opcode) == rkc_pkg::OP_LOAD) begin
                        n_state = rkc_pkg::S_LOAD;
                    end else if (!r_loading) begin
                        n_state = rkc_pkg::S_MULK;
                    end
                end
            end
            rkc_pkg::S_LOAD:  n_state = rkc_pkg::S_IDLE;
            rkc_pkg::S_MULK:  n_state = rkc_pkg::S_ROUND;
            rkc_pkg::S_ROUND: n_state = rkc_pkg::S_DIV;
            rkc_pkg::S_DIV:   n_state = rkc_pkg::S_ACC;
            rkc_pkg::S_ACC:   n_state = rkc_pkg::S_OUT;
            rkc_pkg::S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = rkc_pkg::S_IDLE;
                end
            end
            default: n_state = rkc_pkg::S_IDLE;
        endcase
    end

    // Sequencer strobes
    always_comb begin
        ctrl = '0;
        case (r_state)
            rkc_pkg::S_IDLE:  ctrl.in_ready = 1'b1;
            rkc_pkg::S_LOAD:  ctrl.load_we  = 1'b1;
            rkc_pkg::S_MULK: begin
                ctrl.mul_en = 1'b1;
                ctrl.ram_re = 1'b1;
            end
            rkc_pkg::S_ROUND: ctrl = '0;
            rkc_pkg::S_DIV: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_div = 1'b1;
            end
            rkc_pkg::S_ACC:   ctrl.sum_we = 1'b1;
            rkc_pkg::S_OUT:   ctrl.out_load = !r_out_valid || o_out.ready;
            default:          ctrl = '0;
        endcase
    end

    // Shared multiplier: dt * r, then |k| + d/2 times the reciprocal of 3
    always_comb begin
        if (ctrl.mul_div) begin
            mul_a = {1'b0, div_arg};
            mul_b = rkc_pkg::RECIP3;
        end else begin
            mul_a = {r_time_step[DW-1], r_time_step};
            mul_b = {r_value[DW-1], r_value};
        end
    end

    rkc_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (ctrl.mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Round the Q16.16 product to nearest, ties up, and saturate
    assign prod_rnd = prod + PW'(32768);
    assign prod_sh  = prod_rnd[PW-1:16];
    always_comb begin
        if (prod_sh > SHW'(signed'(32'sh7FFF_FFFF))) begin
            k_sat = 32'sh7FFF_FFFF;
        end else if (prod_sh < SHW'(signed'(32'sh8000_0000))) begin
            k_sat = 32'sh8000_0000;
        end else begin
            k_sat = prod_sh[DW-1:0];
        end
    end

    // Divide |k| by 3 or 6 rounding to nearest, ties away from zero
    assign abs_k    = r_k[DW-1] ? (~r_k + DW'(1)) : r_k;
    assign div_arg  = abs_k + (div6 ? DW'(3) : DW'(1));
    assign q3       = DW'(prod[PW-1:rkc_pkg::RECIP_SH]);
    assign q        = div6 ? (q3 >> 1) : q3;
    assign q_signed = r_k[DW-1] ? -signed'(q) : signed'(q);
    assign ws_sum   = rkc_pkg::sat_add(ws_rd, q_signed);

    // Next evaluation point and its time
    assign sk   = (r_stage == 2'd2) ? r_k : rkc_pkg::half_round(r_k);
    assign hdt  = (r_stage == 2'd0 || r_stage == 2'd1)
                  ? rkc_pkg::half_round(r_time_step) : r_time_step;
    assign elem_next = (r_stage == 2'd3) ? r_ws_new : rkc_pkg::sat_add(ss_rd, sk);
    assign time_next = rkc_pkg::sat_add(r_start_time, hdt);

    // Vector stores
    assign ram_waddr = ctrl.load_we ? load_idx : r_idx;
    assign ss_wdata  = r_value;
    assign ws_wdata  = ctrl.load_we ? r_value : ws_sum;

    rkc_ram #(.WIDTH(DW), .DEPTH(rkc_pkg::MAX_ELEMENTS)) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (ctrl.load_we),
        .i_waddr (ram_waddr),
        .i_wdata (ss_wdata),
        .i_re    (ctrl.ram_re),
        .i_raddr (r_idx),
        .o_rdata (ss_rd)
    );

    rkc_ram #(.WIDTH(DW), .DEPTH(rkc_pkg::MAX_ELEMENTS)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (ctrl.load_we || ctrl.sum_we),
        .i_waddr (ram_waddr),
        .i_wdata (ws_wdata),
        .i_re    (ctrl.ram_re),
        .i_raddr (r_idx),
        .o_rdata (ws_rd)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rkc_pkg::S_IDLE;
            r_loading    <= 1'b1;
            r_stage      <= 2'd0;
            r_idx        <= '0;
            r_start_time <= '0;
            r_time_step  <= rkc_pkg::TIME_STEP_RST;
            r_count      <= rkc_pkg::ELEMENT_COUNT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // Take configuration writes
            if (cfg_accept) begin
                case (rkc_pkg::t_cfg_index'(i_cfg.index))
                    rkc_pkg::CFG_TIME_STEP:     r_time_step <= signed'(i_cfg.data);
                    rkc_pkg::CFG_ELEMENT_COUNT: r_count <= i_cfg.data[rkc_pkg::CNT_W-1:0];
                    default:                    r_count <= r_count;
                endcase
            end

            // Advance the load pointer
            if (ctrl.load_we) begin
                if (load_idx == '0) begin
                    r_start_time <= r_step_time;
                end
                r_stage <= 2'd0;
                if (load_last) begin
                    r_loading <= 1'b0;
                    r_idx     <= '0;
                end else begin
                    r_loading <= 1'b1;
                    r_idx     <= load_idx + IDX_W'(1);
                end
            end

            // Advance element and stage after a result
            if (ctrl.out_load) begin
                if (deriv_last) begin
                    r_idx <= '0;
                    if (r_stage == 2'd3) begin
                        r_stage   <= 2'd0;
                        r_loading <= 1'b1;
                    end else begin
                        r_stage <= r_stage + 2'd1;
                    end
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end

            // Output register handshake
            if (ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op        <= i_in.opcode;
            r_value     <= i_in.value;
            r_step_time <= i_in.step_time;
        end
        if (r_state == rkc_pkg::S_ROUND) begin
            r_k <= k_sat;
        end
        if (ctrl.sum_we) begin
            r_ws_new <= ws_sum;
        end
        if (ctrl.out_load) begin
            r_out_element <= elem_next;
            r_out_final   <= (r_stage == 2'd3) && (rkc_pkg::t_opcode'(r_op) == rkc_pkg::OP_DERIV);
            r_out_time    <= time_next;
            r_out_last    <= deriv_last;
        end
    end

    assign i_in.ready      = ctrl.in_ready;
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_out_valid;
    assign o_out.element   = r_out_element;
    assign o_out.is_final  = r_out_final;
    assign o_out.eval_time = r_out_time;
    assign o_out.last      = r_out_last;
endmodule
`default_nettype wire

@@ design/rkc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rkc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    input  wire logic                                         i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ design/rkc_mul.sv @@
// Shared signed multiplier with a registered product.
`default_nettype none
module rkc_mul (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic signed [rkc_pkg::MUL_W-1:0]      i_a,
    input  wire logic signed [rkc_pkg::MUL_W-1:0]      i_b,
    output      logic signed [rkc_pkg::PROD_W-1:0]     o_prod
);
    logic signed [rkc_pkg::PROD_W-1:0] r_prod;

    // Capture the product when the sequencer issues an operation
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;
endmodule
`default_nettype wire
